// ===== sv/pstrip_pkg.sv =====
package pstrip_pkg;

  localparam int CoordFracBitsDef = 4;

  // Divider geometry: numerator, denominator and quotient widths.
  localparam int NumW = 54;
  localparam int DenW = 39;
  localparam int QuotW = 17;

  localparam int SqW = 34;
  localparam int RadW = 50;
  localparam int RootW = 25;

  localparam int CfgIdxW = 1;
  localparam int SurfW = 13;

  localparam logic [CfgIdxW-1:0] REG_SURF_W = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_SURF_H = 1'd1;
  localparam logic [SurfW-1:0] SURF_RESET = 13'd1024;

  localparam logic [12:0] STRIP_FACTOR = 13'd5000;
  localparam logic signed [13:0] SHADOW_BASE = 14'sd5500;
  localparam logic [13:0] LEN_SCALE = 14'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT_GO,
    ST_ROOT,
    ST_DEN,
    ST_MUL_W,
    ST_MUL_F,
    ST_OFF_GO,
    ST_DIV_OFF,
    ST_VERT,
    ST_TEX_GO,
    ST_DIV_TEX,
    ST_OUT
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/polyline_stroke_strip_builder_core.sv =====
// A point that opens a path is only stored and gives no item.
// A point that closes a segment gives its item after a 25-step root,
// four 17-step divisions for the offsets and four for the texture
// coordinates, the divisions all in one shared divider, with one shared multiplier.
// Such a point holds the input while its item is built, longer while the last item waits.
// Synchronous reset clears the previous point and sets both sizes to 1024.
module polyline_stroke_strip_builder_core
  import pstrip_pkg::*;
#(
  parameter int COORD_FRAC_BITS = CoordFracBitsDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  // point_x, point_y, stroke_width, shadow_jitter, one zero pad bit
  input  logic [55:0]        s_tdata,
  // path_start
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  // left_x, left_y, right_x, right_y, shadow_left_x, shadow_left_y,
  // shadow_right_x, shadow_right_y, left_u, left_v, right_u, right_v
  output logic [191:0]       m_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [SurfW-1:0]   cfg_data
);

  localparam int TexDenW = SurfW + COORD_FRAC_BITS;

  state_t state, state_next;

  logic [SurfW-1:0] surf_w, surf_h;
  logic signed [15:0] prev_x, prev_y;
  logic [15:0] prev_width;
  logic signed [6:0] prev_jitter;
  logic prev_valid;

  logic signed [15:0] px, py;
  logic [15:0] pw;
  logic [12:0] fs;
  logic [15:0] adx, ady;
  logic dx_neg, dy_neg;
  logic [SqW-1:0] sq;
  logic [RootW-1:0] len;
  logic [DenW-1:0] den;
  logic [49:0] mprod;
  logic [1:0] k;
  logic signed [17:0] off [4];
  logic signed [15:0] vert [8];
  logic signed [15:0] tex [4];
  logic tex_neg;

  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] mul_p;

  logic accept;
  logic signed [15:0] in_x, in_y;
  logic signed [16:0] dx, dy;
  logic signed [13:0] fs_wide;

  logic sq_start, sq_done;
  logic [RootW-1:0] sq_root;
  logic dv_start, dv_done;
  logic [NumW-1:0] dv_num;
  logic [DenW-1:0] dv_den;
  logic [QuotW-1:0] dv_q;

  logic [15:0] comp_mag;
  logic comp_neg;
  logic [12:0] factor;
  logic signed [15:0] tex_c;
  logic [16:0] tex_mag;
  logic [SurfW-1:0] tex_s;
  logic [TexDenW-1:0] tex_den;
  logic [17:0] q_ext;

  assign cfg_ready = 1'b1;
  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign in_x = s_tdata[15:0];
  assign in_y = s_tdata[31:16];
  assign dx = 17'(in_x) - 17'(prev_x);
  assign dy = 17'(in_y) - 17'(prev_y);
  assign fs_wide = SHADOW_BASE + {{4{prev_jitter[6]}}, prev_jitter, 3'b000};
  assign mul_p = mul_a * mul_b;

  assign comp_mag = k[0] ? adx : ady;
  assign comp_neg = k[0] ? dx_neg : !dy_neg && (ady != 16'd0);
  assign factor = k[1] ? fs : STRIP_FACTOR;
  assign q_ext = {1'b0, dv_q};

  assign tex_c = vert[{1'b0, k}];
  assign tex_mag = tex_c[15] ? 17'(-17'(tex_c)) : 17'(tex_c);
  assign tex_s = k[0] ? ((surf_h == '0) ? SurfW'(1) : surf_h)
                      : ((surf_w == '0) ? SurfW'(1) : surf_w);
  assign tex_den = TexDenW'(tex_s) << COORD_FRAC_BITS;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    dv_num = '0;
    dv_den = den;
    case (state)
      ST_SQ_X: begin
        mul_a = 33'(adx);
        mul_b = 17'(adx);
      end
      ST_SQ_Y: begin
        mul_a = 33'(ady);
        mul_b = 17'(ady);
      end
      ST_DEN: begin
        mul_a = 33'(len);
        mul_b = 17'(LEN_SCALE);
      end
      ST_MUL_W: begin
        mul_a = 33'(comp_mag);
        mul_b = 17'(pw);
      end
      ST_MUL_F: begin
        mul_a = mprod[32:0];
        mul_b = 17'(factor);
      end
      ST_OFF_GO: begin
        dv_num = NumW'({mprod[44:0], 8'd0}) + NumW'(den >> 1);
      end
      ST_TEX_GO, ST_DIV_TEX: begin
        dv_num = (NumW'(tex_mag) << 14) + NumW'(tex_den >> 1);
        dv_den = DenW'(tex_den);
      end
      default: begin
      end
    endcase
  end

  assign sq_start = (state == ST_ROOT_GO);
  assign dv_start = (state == ST_OFF_GO) || (state == ST_TEX_GO);

  pstrip_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value ({sq[SqW-1:0], 16'd0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  pstrip_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (dv_den),
    .done  (dv_done),
    .quot  (dv_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !s_tuser && prev_valid) begin
          state_next = ST_SQ_X;
        end
      end
      ST_SQ_X: state_next = ST_SQ_Y;
      ST_SQ_Y: state_next = ST_ROOT_GO;
      ST_ROOT_GO: state_next = ST_ROOT;
      ST_ROOT: begin
        if (sq_done) begin
          state_next = ST_DEN;
        end
      end
      ST_DEN: state_next = ST_MUL_W;
      ST_MUL_W: state_next = ST_MUL_F;
      ST_MUL_F: state_next = ST_OFF_GO;
      ST_OFF_GO: state_next = ST_DIV_OFF;
      ST_DIV_OFF: begin
        if (dv_done) begin
          state_next = (k == 2'd3) ? ST_VERT : ST_MUL_W;
        end
      end
      ST_VERT: state_next = ST_TEX_GO;
      ST_TEX_GO: state_next = ST_DIV_TEX;
      ST_DIV_TEX: begin
        if (dv_done) begin
          state_next = (k == 2'd3) ? ST_OUT : ST_TEX_GO;
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      prev_valid <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      prev_width <= '0;
      prev_jitter <= '0;
      surf_w <= SURF_RESET;
      surf_h <= SURF_RESET;
      m_tvalid <= 1'b0;
      k <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        case (cfg_index)
          REG_SURF_W: surf_w <= cfg_data;
          REG_SURF_H: surf_h <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        prev_x <= in_x;
        prev_y <= in_y;
        prev_width <= s_tdata[47:32];
        prev_jitter <= s_tdata[54:48];
        prev_valid <= 1'b1;
      end
      if (state == ST_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_DEN || state == ST_VERT) begin
        k <= '0;
      end else if ((state == ST_DIV_OFF || state == ST_DIV_TEX) && dv_done) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      // The previous point is the one the item describes.
      px <= prev_x;
      py <= prev_y;
      pw <= prev_width;
      fs <= fs_wide[12:0];
      dx_neg <= dx[16];
      dy_neg <= dy[16];
      adx <= dx[16] ? 16'(-dx) : dx[15:0];
      ady <= dy[16] ? 16'(-dy) : dy[15:0];
    end
    case (state)
      ST_SQ_X: sq <= SqW'(mul_p);
      ST_SQ_Y: sq <= sq + SqW'(mul_p);
      ST_ROOT: begin
        if (sq_done) begin
          len <= sq_root;
        end
      end
      ST_DEN: den <= DenW'(mul_p);
      ST_MUL_W, ST_MUL_F: mprod <= mul_p;
      ST_DIV_OFF: begin
        if (dv_done) begin
          // A zero-length segment has no normal and leaves the point in place.
          if (sq == '0) begin
            off[k] <= '0;
          end else begin
            off[k] <= comp_neg ? -$signed(q_ext) : $signed(q_ext);
          end
        end
      end
      ST_VERT: begin
        vert[0] <= sat16(19'(px) - 19'(off[0]));
        vert[1] <= sat16(19'(py) - 19'(off[1]));
        vert[2] <= sat16(19'(px) + 19'(off[0]));
        vert[3] <= sat16(19'(py) + 19'(off[1]));
        vert[4] <= sat16(19'(px) - 19'(off[2]));
        vert[5] <= sat16(19'(py) - 19'(off[3]));
        vert[6] <= sat16(19'(px) + 19'(off[2]));
        vert[7] <= sat16(19'(py) + 19'(off[3]));
      end
      ST_TEX_GO: tex_neg <= tex_c[15];
      ST_DIV_TEX: begin
        if (dv_done) begin
          if (tex_neg) begin
            tex[k] <= dv_q[16] || dv_q[15] ? 16'sh8000 : 16'(-$signed(q_ext));
          end else begin
            tex[k] <= dv_q[16] || dv_q[15] ? 16'sh7fff : dv_q[15:0];
          end
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {tex[3], tex[2], tex[1], tex[0], vert[7], vert[6], vert[5],
                      vert[4], vert[3], vert[2], vert[1], vert[0]};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/pstrip_div.sv =====
module pstrip_div
  import pstrip_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NumW-1:0]   num,
  input  logic [DenW-1:0]   den,
  output logic              done,
  output logic [QuotW-1:0]  quot
);

  logic [DenW-1:0]  rem;
  logic [QuotW-1:0] lo;
  logic [QuotW-1:0] q;
  logic             ovf;
  logic             busy;
  logic [4:0]       cnt;
  logic [DenW:0]    trial;
  logic             ge;

  assign trial = {rem, lo[QuotW-1]};
  assign ge = trial >= {1'b0, den};
  // A quotient that does not fit reads as all ones, which the caller saturates.
  assign quot = ovf ? '1 : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'(QuotW);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DenW'(num[NumW-1:QuotW]);
      lo <= num[QuotW-1:0];
      ovf <= DenW'(num[NumW-1:QuotW]) >= den;
      q <= '0;
    end else if (busy) begin
      rem <= ge ? DenW'(trial - {1'b0, den}) : trial[DenW-1:0];
      lo <= {lo[QuotW-2:0], 1'b0};
      q <= {q[QuotW-2:0], ge};
    end
  end

endmodule

// ===== sv/pstrip_sqrt.sv =====
module pstrip_sqrt
  import pstrip_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RadW-1:0]   value,
  output logic              done,
  output logic [RootW-1:0]  root
);

  logic [RadW-1:0] v;
  logic [RadW:0]   res;
  logic [RadW:0]   bitw;
  logic [RadW:0]   sum;
  logic            busy;
  logic [4:0]      cnt;

  assign sum = res + bitw;
  assign root = res[RootW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= 5'(RootW);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One result bit per cycle, from the top pair of radicand bits downwards.
  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      res <= '0;
      bitw <= (RadW+1)'(1) << (2 * (RootW - 1));
    end else if (busy) begin
      if ({1'b0, v} >= sum) begin
        v <= RadW'({1'b0, v} - sum);
        res <= (res >> 1) + bitw;
      end else begin
        res <= res >> 1;
      end
      bitw <= bitw >> 2;
    end
  end

endmodule

// ===== sv/pstrip_checker.sv =====
module pstrip_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata
);

  // An item waits until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output item dropped while stalled");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("stalled output item changed");

  // A point that opens a path is only stored, so the block is free again.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> s_tready)
    else $error("path start point kept the block busy");

  // A new item only follows a segment computation, during which input waits.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("item appeared without a computation");

endmodule

bind polyline_stroke_strip_builder_core pstrip_checker u_pstrip_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import pstrip_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic signed [6:0]  jit;
    logic               start;
  } point_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [55:0]        s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [191:0]       m_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [SurfW-1:0]   cfg_data;

  polyline_stroke_strip_builder_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  point_t       point_q[$];
  logic [191:0] strip_q[$];
  int           errors = 0;
  int           strips_seen = 0;
  int           points_sent = 0;
  int           hold_cycles = 0;

  // Predictor state: previous point of the current path and surface sizes.
  logic [SurfW-1:0]   surf_w, surf_h;
  logic signed [15:0] last_x, last_y;
  logic [15:0]        last_w;
  logic signed [6:0]  last_jit;
  logic               last_ok;

  string field_name[12] = '{"left_x", "left_y", "right_x", "right_y",
    "shadow_left_x", "shadow_left_y", "shadow_right_x", "shadow_right_y",
    "left_u", "left_v", "right_u", "right_v"};

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint normal_offset(longint comp, longint fac, longint unsigned len);
    if (len == 0) return 0;
    return round_div(comp * longint'(last_w) * fac * 256, 10000 * len);
  endfunction

  function automatic longint tex_coord(longint c, logic [SurfW-1:0] size);
    longint unsigned s;
    s = (size == 0) ? 1 : size;
    return clamp16(round_div(c * 16384, s << CoordFracBitsDef));
  endfunction

  // Strip vertices for the segment ending at p, if p closes one.
  function automatic bit extrude_point(point_t p, output logic [191:0] res);
    longint dx, dy, fs, ox, oy, sx, sy;
    longint v[12];
    longint unsigned len;
    res = '0;
    if (p.start || !last_ok) return 0;
    dx = longint'(p.x) - longint'(last_x);
    dy = longint'(p.y) - longint'(last_y);
    len = int_sqrt(longint'(dx * dx + dy * dy) << 16);
    fs = 5500 + 8 * longint'(last_jit);
    ox = normal_offset(-dy, 5000, len);
    oy = normal_offset(dx, 5000, len);
    sx = normal_offset(-dy, fs, len);
    sy = normal_offset(dx, fs, len);
    v[0] = clamp16(last_x - ox);
    v[1] = clamp16(last_y - oy);
    v[2] = clamp16(last_x + ox);
    v[3] = clamp16(last_y + oy);
    v[4] = clamp16(last_x - sx);
    v[5] = clamp16(last_y - sy);
    v[6] = clamp16(last_x + sx);
    v[7] = clamp16(last_y + sy);
    v[8] = tex_coord(v[0], surf_w);
    v[9] = tex_coord(v[1], surf_h);
    v[10] = tex_coord(v[2], surf_w);
    v[11] = tex_coord(v[3], surf_h);
    for (int k = 0; k < 12; k++) res[16*k +: 16] = v[k][15:0];
    return 1;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %0s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  // Sender: bursts of random length with random gaps.
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (point_q.size() > 0) begin
        point_t p;
        p = point_q.pop_front();
        s_tdata  <= {1'b0, p.jit, p.w, p.y, p.x};
        s_tuser  <= p.start;
        s_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus a long hold-off on request.
  int rx_left = 0, rx_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 300);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 2) != 0);
        default: m_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Predict on accepted points, check accepted strip items.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      point_t p;
      logic [191:0] r;
      p.x = s_tdata[15:0];
      p.y = s_tdata[31:16];
      p.w = s_tdata[47:32];
      p.jit = s_tdata[54:48];
      p.start = s_tuser;
      if (extrude_point(p, r)) strip_q = {strip_q, r};
      last_x = p.x;
      last_y = p.y;
      last_w = p.w;
      last_jit = p.jit;
      last_ok = 1'b1;
      points_sent++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (strip_q.size() == 0) begin
        report("unexpected item", m_tdata[15:0], 16'd0);
      end else begin
        logic [191:0] e;
        e = strip_q.pop_front();
        for (int k = 0; k < 12; k++)
          if (m_tdata[16*k +: 16] !== e[16*k +: 16])
            report(field_name[k], m_tdata[16*k +: 16], e[16*k +: 16]);
        strips_seen++;
      end
    end
  end

  function automatic point_t pt(int x, int y, int w, int j, bit s);
    point_t p;
    p.x = 16'(x);
    p.y = 16'(y);
    p.w = 16'(w);
    p.jit = 7'(j);
    p.start = s;
    return p;
  endfunction

  function automatic void queue_point(point_t p);
    point_q = {point_q, p};
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [SurfW-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SURF_W) surf_w = val;
    else surf_h = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (point_q.size() > 0 || s_tvalid || strip_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Mostly well-formed paths of nearby points, some full-range noise.
  task automatic random_points(int count);
    int n, len, cx, cy;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_point(pt($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1) == 1));
        n++;
      end else begin
        len = $urandom_range(2, 10);
        cx = $signed(16'($urandom));
        cy = $signed(16'($urandom));
        for (int i = 0; i < len; i++) begin
          int w;
          w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2000);
          if ($urandom_range(0, 4) == 0) begin
            cx = cx + $signed(16'($urandom));
            cy = cy + $signed(16'($urandom));
          end else begin
            cx = cx + $urandom_range(0, 800) - 400;
            cy = cy + $urandom_range(0, 800) - 400;
          end
          queue_point(pt(cx, cy, w, $urandom_range(0, 99) - 50, i == 0));
          n++;
        end
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    surf_w = SURF_RESET;
    surf_h = SURF_RESET;
    last_x = 0;
    last_y = 0;
    last_w = 0;
    last_jit = 0;
    last_ok = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: no start flag on the very first point, extremes, zero length.
    queue_point(pt(100, 200, 64, 0, 0));
    queue_point(pt(260, 200, 64, 0, 0));
    queue_point(pt(260, 200, 65535, -64, 0));
    queue_point(pt(260, 200, 0, 63, 0));
    queue_point(pt(-32768, -32768, 65535, 63, 1));
    queue_point(pt(32767, 32767, 65535, -64, 0));
    queue_point(pt(-32768, 32767, 65535, -50, 0));
    queue_point(pt(32767, -32768, 0, 49, 0));
    queue_point(pt(0, 0, 32768, 0, 0));
    queue_point(pt(5, 7, 100, -1, 1));
    queue_point(pt(5, 7, 100, 1, 1));
    queue_point(pt(5, 9, 100, 0, 0));
    queue_point(pt(32767, 32767, 65535, 0, 0));
    queue_point(pt(32767, 32767, 65535, 0, 0));
    queue_point(pt(-1, -1, 1, -64, 0));
    queue_point(pt(0, 0, 0, 0, 0));
    wait_drained();

    write_reg(REG_SURF_W, 13'd1);
    write_reg(REG_SURF_H, 13'd8191);
    random_points(380);
    wait_drained();

    // Hold the output back while points keep coming.
    write_reg(REG_SURF_W, 13'd4096);
    write_reg(REG_SURF_H, 13'd1);
    hold_cycles = 2000;
    random_points(380);
    wait_drained();

    write_reg(REG_SURF_W, 13'd0);
    write_reg(REG_SURF_H, 13'd0);
    random_points(380);
    wait_drained();

    for (int ph = 0; ph < 2; ph++) begin
      write_reg(REG_SURF_W, 13'($urandom_range(1, 8191)));
      write_reg(REG_SURF_H, 13'($urandom_range(1, 8191)));
      random_points(380);
      wait_drained();
    end

    $display("%0d points driven, %0d strip items checked across six surface settings",
             points_sent, strips_seen);
    if (errors == 0 && strip_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(64'd4000000 * 20);
    $display("simulation failed");
    $finish;
  end

endmodule
